// ----- sv/positional_list_store_unit_macros.svh -----
// Assertion macros for the positional list store unit.
// Used by positional_list_store_unit.sv; no other dependencies.
`ifndef POSITIONAL_LIST_STORE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_STORE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PLSU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("plsu: same-cycle check failed");
// next-cycle implication
`define PLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("plsu: next-cycle check failed");
`else
`define PLSU_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/plsu_pkg.sv -----
// Shared constants for the positional list store unit.
// No dependencies.
package plsu_pkg;

	localparam int DEPTH = 16;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // entry address bits
	localparam int CW    = $clog2(DEPTH + 1);                // entry count bits

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_DUMP   = 2'd2;

	// placement codes
	localparam logic [1:0] AT_FRONT = 2'd0;
	localparam logic [1:0] AT_BACK  = 2'd1;
	localparam logic [1:0] AT_POS   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

endpackage

// ----- sv/positional_list_store_unit.sv -----
// Positional list store: bounded ordered list with insert, delete and dump.
// Depends on plsu_pkg and positional_list_store_unit_macros.svh.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------------
//  request | req_valid / req_stall | req_type, where, position, value
//  result  | rsp_valid / rsp_stall | status, entry_index, entry_value, occupancy, last
//
// One request at a time. Insert and delete shift the entries that move, insert
// then writes the new word, and the result is posted; the shift runs one entry
// per cycle through the single read / single write port of the entry memory.
// A dump reads each stored entry, then posts it.
// Reset clears the count and the control and result registers; entry memory is never cleared.
// A stalled result holds the block in its posting state; requests are taken
// only in idle. All result fields are registered and hold while stalled.
`include "positional_list_store_unit_macros.svh"

module positional_list_store_unit (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [1:0]  where,
	input  logic [5:0]  position,
	input  logic signed [31:0] value,
	// result channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [5:0]  entry_index,
	output logic signed [31:0] entry_value,
	output logic [6:0]  occupancy,
	output logic        last
);

	localparam int IW = plsu_pkg::IW;
	localparam int CW = plsu_pkg::CW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,     // shifting up, then writing new value
		S_DEL,     // shifting down over the removed slot
		S_DRD,     // dump: read entry
		S_DWT,     // dump: post entry
		S_RESP     // post single result
	} state_t;

	state_t state_q;

	logic [CW-1:0] count_q;    // entries held
	logic [CW-1:0] ptr_q;      // shift / dump cursor
	logic [CW-1:0] slot_q;     // target slot of insert
	logic [1:0]    status_q;   // status of pending single result
	logic [31:0]   value_q;    // word to insert

	// shift pipeline: read issued last cycle, write due now
	logic          pend_s1;
	logic [IW-1:0] pend_addr_s1;

	// entry memory, one read and one write port, registered read data
	logic [31:0]   mem_q [plsu_pkg::DEPTH];
	logic [31:0]   rd_data_q;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;

	// result register
	logic          rsp_valid_q;
	logic [1:0]    status_q_o;
	logic [5:0]    entry_index_q;
	logic [31:0]   entry_value_q;
	logic [6:0]    occupancy_q;
	logic          last_q;

	logic          out_free;
	logic          rsp_post;   // a new transaction enters the result register
	logic          req_take;

	// request decode (compared at 8 bits so count+1 never wraps)
	logic [7:0]    pos_ext;
	logic [7:0]    cnt_ext;
	logic [1:0]    dec_status;
	logic [CW-1:0] dec_slot;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_post = out_free && (state_q == S_DWT || state_q == S_RESP);
	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && (state_q == S_IDLE);

	assign pos_ext = 8'(position);
	assign cnt_ext = 8'(count_q);

	always_comb begin
		dec_status = plsu_pkg::ST_OK;
		dec_slot   = '0;
		case (req_type)
			plsu_pkg::REQ_INSERT: begin
				if (count_q == CW'(plsu_pkg::DEPTH)) begin
					dec_status = plsu_pkg::ST_FULL;
				end else if (where == plsu_pkg::AT_FRONT) begin
					dec_slot = '0;
				end else if (where == plsu_pkg::AT_BACK) begin
					dec_slot = count_q;
				end else if (where == plsu_pkg::AT_POS && pos_ext >= 8'd1 &&
						pos_ext <= cnt_ext + 8'd1) begin
					dec_slot = CW'(pos_ext - 8'd1);
				end else begin
					dec_status = plsu_pkg::ST_RANGE;
				end
			end
			plsu_pkg::REQ_DELETE: begin
				if (count_q == '0) begin
					dec_status = plsu_pkg::ST_EMPTY;
				end else if (where == plsu_pkg::AT_FRONT) begin
					dec_slot = '0;
				end else if (where == plsu_pkg::AT_BACK) begin
					dec_slot = count_q - 1'b1;
				end else if (where == plsu_pkg::AT_POS && pos_ext >= 8'd1 &&
						pos_ext <= cnt_ext) begin
					dec_slot = CW'(pos_ext - 8'd1);
				end else begin
					dec_status = plsu_pkg::ST_RANGE;
				end
			end
			plsu_pkg::REQ_DUMP: begin
				if (count_q == '0) begin
					dec_status = plsu_pkg::ST_EMPTY;
				end
			end
			default: begin
				dec_status = plsu_pkg::ST_OK;
			end
		endcase
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pend_addr_s1;
		mem_wdata = rd_data_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_q[IW-1:0];
		unique case (state_q)
			S_INS: begin
				if (pend_s1) begin
					mem_we = 1'b1;
				end else if (ptr_q == slot_q) begin
					mem_we    = 1'b1;
					mem_waddr = slot_q[IW-1:0];
					mem_wdata = value_q;
				end
				if (ptr_q > slot_q) begin
					mem_re    = 1'b1;
					mem_raddr = IW'(ptr_q - 1'b1);
				end
			end
			S_DEL: begin
				mem_we = pend_s1;
				mem_re = (ptr_q < count_q);
			end
			S_DRD: begin
				mem_re = 1'b1;
			end
			S_IDLE, S_DWT, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_raddr];
		end
	end

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			ptr_q         <= '0;
			slot_q        <= '0;
			status_q      <= plsu_pkg::ST_OK;
			value_q       <= '0;
			pend_s1       <= 1'b0;
			pend_addr_s1  <= '0;
			rsp_valid_q   <= 1'b0;
			status_q_o    <= plsu_pkg::ST_OK;
			entry_index_q <= '0;
			entry_value_q <= '0;
			occupancy_q   <= '0;
			last_q        <= 1'b0;
		end else begin
			if (rsp_post) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						status_q <= dec_status;
						value_q  <= value;
						slot_q   <= dec_slot;
						pend_s1  <= 1'b0;
						if (dec_status != plsu_pkg::ST_OK) begin
							state_q <= S_RESP;
						end else if (req_type == plsu_pkg::REQ_INSERT) begin
							ptr_q   <= count_q;
							state_q <= S_INS;
						end else if (req_type == plsu_pkg::REQ_DELETE) begin
							ptr_q   <= dec_slot + 1'b1;
							state_q <= S_DEL;
						end else if (req_type == plsu_pkg::REQ_DUMP) begin
							ptr_q   <= '0;
							state_q <= S_DRD;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_INS: begin
					if (ptr_q > slot_q) begin
						pend_s1      <= 1'b1;
						pend_addr_s1 <= ptr_q[IW-1:0];
						ptr_q        <= ptr_q - 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							count_q <= count_q + 1'b1;
							state_q <= S_RESP;
						end
					end
				end
				S_DEL: begin
					if (ptr_q < count_q) begin
						pend_s1      <= 1'b1;
						pend_addr_s1 <= IW'(ptr_q - 1'b1);
						ptr_q        <= ptr_q + 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							count_q <= count_q - 1'b1;
							state_q <= S_RESP;
						end
					end
				end
				S_DRD: begin
					state_q <= S_DWT;
				end
				S_DWT: begin
					if (out_free) begin
						status_q_o    <= plsu_pkg::ST_OK;
						entry_index_q <= 6'(ptr_q + 1'b1);
						entry_value_q <= rd_data_q;
						occupancy_q   <= 7'(count_q);
						last_q        <= (CW'(ptr_q + 1'b1) == count_q);
						ptr_q         <= ptr_q + 1'b1;
						state_q       <= (CW'(ptr_q + 1'b1) == count_q) ? S_IDLE : S_DRD;
					end
				end
				S_RESP: begin
					if (out_free) begin
						status_q_o    <= status_q;
						entry_index_q <= '0;
						entry_value_q <= '0;
						occupancy_q   <= 7'(count_q);
						last_q        <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q_o;
	assign entry_index = entry_index_q;
	assign entry_value = entry_value_q;
	assign occupancy   = occupancy_q;
	assign last        = last_q;

	// count stays within capacity
	`PLSU_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(plsu_pkg::DEPTH))
	// count moves by at most one per cycle
	`PLSU_ASSERT_NEXT(a_count_step, clk, arst_n, 1'b1,
		count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1)
	// only dump entries come without last, and they carry an index
	`PLSU_ASSERT_IMPLY(a_mid_dump, clk, arst_n, rsp_valid && !last, status == plsu_pkg::ST_OK && entry_index != 6'd0)
	// a pending shift write exists only while shifting
	`PLSU_ASSERT_IMPLY(a_pend_state, clk, arst_n, pend_s1, state_q == S_INS || state_q == S_DEL)

endmodule

// ----- test/tb_positional_list_store_unit.sv -----
`timescale 1ns / 100ps
// Testbench for positional_list_store_unit: directed and random insert, delete and dump
// requests, with results checked against a list model kept in the bench.
// Depends on plsu_pkg and the positional_list_store_unit RTL.
module tb_positional_list_store_unit;

	localparam int N_RANDOM  = 140;
	localparam int MAX_WAIT  = 17;
	localparam int MAX_SHOWN = 10;
	localparam int PHASE_LEN = 24;
	// codes the package leaves unnamed; the block must still handle them
	localparam logic [1:0] REQ_IGNORED = 2'd3;
	localparam logic [1:0] AT_BAD      = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         loc;
		logic [5:0]         pos;
		logic signed [31:0] word;
		logic               drain;  // hold this one back until all results are in
	} list_request_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         index;
		logic signed [31:0] word;
		logic [6:0]         occupancy;
		logic               last;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         req_type = plsu_pkg::REQ_INSERT;
	logic [1:0]         where = plsu_pkg::AT_FRONT;
	logic [5:0]         position = '0;
	logic signed [31:0] value = '0;

	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [1:0]         status;
	logic [5:0]         entry_index;
	logic signed [31:0] entry_value;
	logic [6:0]         occupancy;
	logic               last;

	positional_list_store_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.where       (where),
		.position    (position),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.occupancy   (occupancy),
		.last        (last)
	);

	always #2 clk = ~clk;

	// stimulus not yet sent, and results owed by the block in arrival order
	list_request_t queued_requests[$];
	list_result_t  awaited_results[$];

	// list model: the words front to back and how many are stored
	logic signed [31:0] list_words [plsu_pkg::DEPTH];
	int list_len = 0;

	// generator's own running length, only used to pick sensible positions
	int gen_len = 0;

	int requests_total    = 0;
	int requests_accepted = 0;
	int fail_count        = 0;

	list_request_t in_flight;
	int send_wait  = 0;
	int send_calm  = 0;
	int recv_wait  = 0;
	int recv_calm  = 0;

	// Per-transaction wait, 0..MAX_WAIT, with occasional stretches of no waiting at all.
	task automatic draw_wait(inout int calm_left, output int cycles);
		if (calm_left > 0) begin
			calm_left--;
			cycles = 0;
		end else begin
			if ($urandom_range(0, 9) == 0)
				calm_left = $urandom_range(8, 30);
			cycles = $urandom_range(0, MAX_WAIT);
		end
	endtask

	task automatic owe_result(input logic [1:0] st, input int idx,
	                          input logic signed [31:0] w, input logic lst);
		list_result_t r;
		r.status    = st;
		r.index     = idx[5:0];
		r.word      = w;
		r.occupancy = list_len[6:0];
		r.last      = lst;
		awaited_results = {awaited_results, r};
	endtask

	// Apply one accepted transaction to the list model and record what it must produce.
	// Full / empty are checked before the placement; an unknown placement is out of range.
	task automatic apply_to_list(input list_request_t rq);
		int slot;
		int i;
		logic [1:0] st;
		st   = plsu_pkg::ST_OK;
		slot = -1;
		case (rq.kind)
			plsu_pkg::REQ_INSERT: begin
				if (list_len >= plsu_pkg::DEPTH) begin
					st = plsu_pkg::ST_FULL;
				end else begin
					case (rq.loc)
						plsu_pkg::AT_FRONT: slot = 0;
						plsu_pkg::AT_BACK:  slot = list_len;
						plsu_pkg::AT_POS:
							if (rq.pos >= 1 && rq.pos <= list_len + 1) slot = rq.pos - 1;
						default:  slot = -1;
					endcase
					if (slot < 0) begin
						st = plsu_pkg::ST_RANGE;
					end else begin
						for (i = list_len; i > slot; i--)
							list_words[i] = list_words[i - 1];
						list_words[slot] = rq.word;
						list_len++;
					end
				end
				owe_result(st, 0, '0, 1'b1);
			end
			plsu_pkg::REQ_DELETE: begin
				if (list_len == 0) begin
					st = plsu_pkg::ST_EMPTY;
				end else begin
					case (rq.loc)
						plsu_pkg::AT_FRONT: slot = 0;
						plsu_pkg::AT_BACK:  slot = list_len - 1;
						plsu_pkg::AT_POS:
							if (rq.pos >= 1 && rq.pos <= list_len) slot = rq.pos - 1;
						default:  slot = -1;
					endcase
					if (slot < 0) begin
						st = plsu_pkg::ST_RANGE;
					end else begin
						for (i = slot; i + 1 < list_len; i++)
							list_words[i] = list_words[i + 1];
						list_len--;
					end
				end
				owe_result(st, 0, '0, 1'b1);
			end
			plsu_pkg::REQ_DUMP: begin
				if (list_len == 0) begin
					owe_result(plsu_pkg::ST_EMPTY, 0, '0, 1'b1);
				end else begin
					for (i = 0; i < list_len; i++)
						owe_result(plsu_pkg::ST_OK, i + 1, list_words[i], i == list_len - 1);
				end
			end
			default: owe_result(plsu_pkg::ST_OK, 0, '0, 1'b1);  // unknown request: no change
		endcase
	endtask

	task automatic check_result(input list_result_t got);
		list_result_t want;
		if (awaited_results.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_SHOWN)
				$display("%0t: result with nothing owed: status %0d index %0d value %0d occ %0d last %0d",
				         $realtime, got.status, got.index, got.word, got.occupancy, got.last);
		end else begin
			want = awaited_results.pop_front();
			if (got.status !== want.status || got.index !== want.index ||
			    got.word !== want.word || got.occupancy !== want.occupancy ||
			    got.last !== want.last) begin
				fail_count++;
				if (fail_count <= MAX_SHOWN)
					$display("%0t: mismatch: expected status %0d index %0d value %0d occ %0d last %0d, got status %0d index %0d value %0d occ %0d last %0d",
					         $realtime, want.status, want.index, want.word, want.occupancy,
					         want.last, got.status, got.index, got.word, got.occupancy,
					         got.last);
			end
		end
	endtask

	// Request driver. A stalled transaction keeps its payload; on acceptance the model
	// is updated, then the drawn gap runs before the next one goes out. A request marked
	// drain waits until the block has returned every result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			send_wait = 0;
		end else if (!(req_valid && req_stall)) begin
			if (req_valid) begin
				apply_to_list(in_flight);
				requests_accepted++;
			end
			if (send_wait > 0) begin
				send_wait--;
				req_valid <= 1'b0;
			end else if (queued_requests.size() > 0 &&
			             (!queued_requests[0].drain ||
			              (!req_valid && awaited_results.size() == 0))) begin
				in_flight = queued_requests.pop_front();
				req_type  <= in_flight.kind;
				where     <= in_flight.loc;
				position  <= in_flight.pos;
				value     <= in_flight.word;
				req_valid <= 1'b1;
				draw_wait(send_calm, send_wait);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result monitor. Stall runs off its own counter, so it lands on any phase of the
	// block's work, busy or not.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			recv_wait = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				check_result({status, entry_index, entry_value, occupancy, last});
				draw_wait(recv_calm, recv_wait);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic queue_request(input logic [1:0] kind, input logic [1:0] loc,
	                             input logic [5:0] pos, input logic signed [31:0] word,
	                             input logic drain);
		list_request_t rq;
		rq.kind  = kind;
		rq.loc   = loc;
		rq.pos   = pos;
		rq.word  = word;
		rq.drain = drain;
		queued_requests = {queued_requests, rq};
		// rough length tracking so random positions mostly land in range
		if (kind == plsu_pkg::REQ_INSERT && gen_len < plsu_pkg::DEPTH &&
		    (loc == plsu_pkg::AT_FRONT || loc == plsu_pkg::AT_BACK ||
		     (loc == plsu_pkg::AT_POS && pos >= 1 && pos <= gen_len + 1)))
			gen_len++;
		else if (kind == plsu_pkg::REQ_DELETE && gen_len > 0 &&
		         (loc == plsu_pkg::AT_FRONT || loc == plsu_pkg::AT_BACK ||
		          (loc == plsu_pkg::AT_POS && pos >= 1 && pos <= gen_len)))
			gen_len--;
	endtask

	initial begin
		int n;
		int phase;
		int roll;
		int ins_pct;
		logic [1:0] kind;
		logic [1:0] loc;
		logic [5:0] pos;

		// directed: empty list cases, placement edges, word extremes, unknown codes
		queue_request(plsu_pkg::REQ_DUMP,   plsu_pkg::AT_FRONT, 6'd0,  32'sd0, 1'b0);
		queue_request(plsu_pkg::REQ_DELETE, plsu_pkg::AT_FRONT, 6'd0,  32'sd0, 1'b0);
		// empty wins over position
		queue_request(plsu_pkg::REQ_DELETE, plsu_pkg::AT_POS,   6'd1,  32'sd0, 1'b0);
		queue_request(plsu_pkg::REQ_INSERT, plsu_pkg::AT_POS,   6'd0,  32'sd5, 1'b0);
		queue_request(plsu_pkg::REQ_INSERT, plsu_pkg::AT_POS,   6'd2,  32'sd6, 1'b0);
		queue_request(plsu_pkg::REQ_INSERT, plsu_pkg::AT_FRONT, 6'd0,  32'h7FFF_FFFF, 1'b0);
		queue_request(plsu_pkg::REQ_INSERT, plsu_pkg::AT_BACK,  6'd0,  32'h8000_0000, 1'b0);
		queue_request(plsu_pkg::REQ_INSERT, plsu_pkg::AT_POS,   6'd2,  -32'sd1, 1'b0);
		// one past the end
		queue_request(plsu_pkg::REQ_INSERT, plsu_pkg::AT_POS,   6'd4,  32'sd0, 1'b0);
		queue_request(plsu_pkg::REQ_INSERT, AT_BAD,             6'd1,  32'sd7, 1'b0);
		queue_request(REQ_IGNORED,          plsu_pkg::AT_FRONT, 6'd0,  32'sd0, 1'b0);
		queue_request(plsu_pkg::REQ_DUMP,   plsu_pkg::AT_FRONT, 6'd0,  32'sd0, 1'b0);
		queue_request(plsu_pkg::REQ_DELETE, plsu_pkg::AT_POS,   6'd5,  32'sd0, 1'b0);
		queue_request(plsu_pkg::REQ_DELETE, plsu_pkg::AT_POS,   6'd0,  32'sd0, 1'b0);
		queue_request(plsu_pkg::REQ_DELETE, AT_BAD,             6'd1,  32'sd0, 1'b0);
		queue_request(plsu_pkg::REQ_DELETE, plsu_pkg::AT_POS,   6'd63, 32'sd0, 1'b0);
		queue_request(plsu_pkg::REQ_INSERT, plsu_pkg::AT_POS,   6'd63, 32'sd9, 1'b0);
		queue_request(plsu_pkg::REQ_DELETE, plsu_pkg::AT_POS,   6'd2,  32'sd0, 1'b0);
		queue_request(plsu_pkg::REQ_DELETE, plsu_pkg::AT_BACK,  6'd0,  32'sd0, 1'b0);
		queue_request(plsu_pkg::REQ_DELETE, plsu_pkg::AT_FRONT, 6'd0,  32'sd0, 1'b0);
		queue_request(plsu_pkg::REQ_DUMP,   plsu_pkg::AT_FRONT, 6'd0,  32'sd0, 1'b0);

		// random: fill, mixed, drain, mixed with dumps; a little noise everywhere
		for (n = 0; n < N_RANDOM; n++) begin
			phase = (n / PHASE_LEN) % 4;
			roll  = $urandom_range(0, 99);
			pos   = 6'($urandom_range(0, 63));
			if (roll < 6) begin
				kind = 2'($urandom_range(0, 3));
				loc  = 2'($urandom_range(0, 3));
			end else begin
				loc = 2'($urandom_range(0, 2));
				if (phase == 0)
					ins_pct = 100;
				else if (phase == 2)
					ins_pct = 15;
				else
					ins_pct = 55;
				if ((phase == 0 && gen_len == plsu_pkg::DEPTH && roll < 30) ||
				    (phase != 0 && roll < (phase == 3 ? 26 : 14)))
					kind = plsu_pkg::REQ_DUMP;
				else if ($urandom_range(0, 99) < ins_pct)
					kind = plsu_pkg::REQ_INSERT;
				else
					kind = plsu_pkg::REQ_DELETE;
				if (loc == plsu_pkg::AT_POS && kind == plsu_pkg::REQ_INSERT)
					pos = 6'($urandom_range(1, gen_len + 1));
				else if (loc == plsu_pkg::AT_POS && kind == plsu_pkg::REQ_DELETE)
					pos = 6'($urandom_range(1, (gen_len > 0) ? gen_len : 1));
			end
			queue_request(kind, loc, pos, $urandom(), n % 50 == 25);
		end
		requests_total = queued_requests.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (!(requests_accepted == requests_total && awaited_results.size() == 0))
			@(negedge clk);
		// catch any stray result after the last one owed
		repeat (4 * plsu_pkg::DEPTH + 8) @(negedge clk);
		if (fail_count == 0)
			$display("tb_positional_list_store_unit passed");
		else
			$display("tb_positional_list_store_unit failed");
		$finish;
	end

	// worst case is far below this: 161 transactions, each a full dump under full stall
	initial begin
		#2000000;
		$display("tb_positional_list_store_unit failed");
		$finish;
	end

endmodule
